// ----- rtl/core/vre_pkg.sv -----
// Shared types and constants for the vector reduction engine.
package vre_pkg;

  // Reduction modes; codes 10 to 15 are left unused and ignore elements
  typedef enum logic [3:0] {
    MODE_MIN       = 4'd0,
    MODE_MAX       = 4'd1,
    MODE_L1        = 4'd2,
    MODE_L2        = 4'd3,
    MODE_MAXABS    = 4'd4,
    MODE_DOT       = 4'd5,
    MODE_MINQUOT   = 4'd6,
    MODE_WRMS      = 4'd7,
    MODE_WRMS_MASK = 4'd8,
    MODE_EQUALS    = 4'd9
  } mode_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL  = 2'd1;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] Q32_ONE = 64'sh0000_0001_0000_0000;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;

  // One classified element handed from front to back
  typedef struct packed {
    logic signed [63:0] term;
    logic               skip;
    logic               clip;
    logic               neq;
    logic               last;
  } work_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_MUL,
    F_SQ,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_RUN,
    B_DIV,
    B_SQRT,
    B_OUT
  } back_state_e;

  // Accumulator start value of a mode
  function automatic logic signed [63:0] init_acc(mode_e m);
    logic signed [63:0] v;
    case (m)
      MODE_MIN, MODE_MINQUOT: v = S64_MAX;
      MODE_MAX:               v = S64_MIN;
      default:                v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/vector_reduction_engine.sv -----
// Top level of the vector reduction engine: config registers, front, queue, back.
//
//  channel  | direction | signals                          | payload
//  ---------+-----------+----------------------------------+-------------------------------
//  s_axis   | in        | s_axis_tvalid/tready/tdata/tlast | own, other, mask; tlast = last
//  m_axis   | out       | m_axis_tvalid/tready/tdata/tuser | result; tuser = equal, saturated
//  cfg      | in        | cfg_valid_i/ready_o/index/data   | 0 mode, 1 tolerance
//
// The front holds one element until its term is pushed: a multiply state (plus a
// squaring state in WRMS modes), or a radix-2 divider with one quotient bit per cycle
// (min-quotient mode). The back adds one queued term per cycle while running; after
// the last element it takes the root (L2), or divides by the count, then roots (WRMS).
// Reset restores mode min, tolerance zero and an empty reduction; no clearing pass.
// A stalled result holds the back; the front keeps filling the 4-entry queue.
module vector_reduction_engine import vre_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [95:0]          s_axis_tdata,   // own [31:0], other [63:32], mask [95:64]
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [63:0]          m_axis_tdata,   // result [63:0]
  output logic [1:0]           m_axis_tuser,   // equal_flag [0], saturated [1]
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  mode_e       mode_q;
  logic [30:0] tol_q;
  logic        restart;
  mode_e       restart_mode;

  // Configuration registers
  assign cfg_ready_o  = 1'b1;
  assign restart      = cfg_valid_i && (cfg_index_i == CFG_MODE);
  assign restart_mode = mode_e'(cfg_data_i[3:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MIN;
      tol_q  <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MODE) mode_q <= restart_mode;
      else if (cfg_index_i == CFG_TOL) tol_q <= cfg_data_i[30:0];
    end
  end

  work_t front_work, queue_work;
  logic  front_push, queue_ready, queue_valid, back_pop;
  logic  equal, sat;

  vre_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .tol_i        (tol_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .own_i        (s_axis_tdata[31:0]),
    .oth_i        (s_axis_tdata[63:32]),
    .msk_i        (s_axis_tdata[95:64]),
    .last_i       (s_axis_tlast),
    .push_o       (front_push),
    .push_ready_i (queue_ready),
    .work_o       (front_work)
  );

  vre_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .ready_o (queue_ready),
    .data_i  (front_work),
    .valid_o (queue_valid),
    .pop_i   (back_pop),
    .data_o  (queue_work)
  );

  vre_back #(
    .CountBits (COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .restart_i      (restart),
    .restart_mode_i (restart_mode),
    .work_valid_i   (queue_valid),
    .work_i         (queue_work),
    .pop_o          (back_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_o       (m_axis_tdata),
    .equal_o        (equal),
    .sat_o          (sat)
  );

  assign m_axis_tuser = {sat, equal};

endmodule

// ----- rtl/core/vre_front.sv -----
// Front end: takes an element and forms its per-mode term (products, quotient, compare).
module vre_front import vre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mode_e              mode_i,
  input  logic [30:0]        tol_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] own_i,
  input  logic signed [31:0] oth_i,
  input  logic signed [31:0] msk_i,
  input  logic               last_i,
  output logic               push_o,
  input  logic               push_ready_i,
  output work_t              work_o
);

  front_state_e       state_q, state_d;
  logic signed [31:0] own_q, oth_q, msk_q;
  logic               last_q;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] sq_q, sq_d;
  logic               wclip_q, wclip_d;
  logic [63:0]        num_q, num_d;
  logic [31:0]        rem_q, rem_d;
  logic [63:0]        quo_q, quo_d;
  logic [5:0]         step_q, step_d;

  logic signed [31:0] mul_b;
  logic [31:0]        abs_own, abs_oth;
  logic [32:0]        shifted;
  logic signed [63:0] w_full;
  logic signed [31:0] w_sat;
  logic               w_ovf;

  assign abs_own = own_q[31] ? 32'(-own_q) : own_q;
  assign abs_oth = oth_q[31] ? 32'(-oth_q) : oth_q;
  assign mul_b   = (mode_i == MODE_L2) ? own_q : oth_q;
  assign shifted = {rem_q, num_q[63]};

  // WRMS product back to Q16.16 with floor, then clipped to 32 bits
  assign w_full = prod_q >>> 16;
  assign w_ovf  = !((&w_full[63:31]) || !(|w_full[63:31]));
  assign w_sat  = !w_ovf ? w_full[31:0] :
                  (w_full[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  // Sequencer
  always_comb begin
    state_d    = state_q;
    prod_d     = prod_q;
    sq_d       = sq_q;
    wclip_d    = wclip_q;
    num_d      = num_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) state_d = F_MUL;
      end
      F_MUL: begin
        // signed 32 x 32 product
        prod_d = own_q * mul_b;
        if (mode_i == MODE_WRMS || mode_i == MODE_WRMS_MASK) begin
          state_d = F_SQ;
        end else if (mode_i == MODE_MINQUOT && own_q != '0) begin
          num_d   = {abs_oth, 32'b0};
          rem_d   = '0;
          quo_d   = '0;
          step_d  = '0;
          state_d = F_DIV;
        end else begin
          state_d = F_PUSH;
        end
      end
      F_SQ: begin
        sq_d    = w_sat * w_sat;
        wclip_d = w_ovf;
        state_d = F_PUSH;
      end
      F_DIV: begin
        // one quotient bit per cycle
        if (shifted >= {1'b0, abs_own}) begin
          rem_d = 32'(shifted - {1'b0, abs_own});
          quo_d = {quo_q[62:0], 1'b1};
        end else begin
          rem_d = shifted[31:0];
          quo_d = {quo_q[62:0], 1'b0};
        end
        num_d  = {num_q[62:0], 1'b0};
        step_d = step_q + 6'd1;
        if (step_q == 6'd63) state_d = F_PUSH;
      end
      F_PUSH: begin
        push_o = 1'b1;
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Term per mode
  logic signed [63:0] q, aq, quot;
  logic               quot_clip, qneg;
  logic signed [32:0] diff;
  logic [32:0]        adiff;

  assign q     = {{16{own_q[31]}}, own_q, 16'b0};
  assign aq    = own_q[31] ? -q : q;
  assign qneg  = oth_q[31] ^ own_q[31];
  assign diff  = 33'(own_q) - 33'(oth_q);
  assign adiff = diff[32] ? 33'(-diff) : 33'(diff);

  always_comb begin
    quot      = $signed(quo_q);
    quot_clip = 1'b0;
    if (!qneg) begin
      if (quo_q[63]) begin
        quot      = S64_MAX;
        quot_clip = 1'b1;
      end
    end else if (quo_q[63]) begin
      quot      = S64_MIN;
      quot_clip = |quo_q[62:0];
    end else begin
      quot = -$signed(quo_q);
    end
  end

  always_comb begin
    work_o      = '0;
    work_o.last = last_q;
    case (mode_i)
      MODE_MIN, MODE_MAX:    work_o.term = q;
      MODE_L1, MODE_MAXABS:  work_o.term = aq;
      MODE_L2, MODE_DOT:     work_o.term = prod_q;
      MODE_MINQUOT: begin
        work_o.term = quot;
        work_o.skip = (own_q == '0);
        work_o.clip = quot_clip && (own_q != '0);
      end
      MODE_WRMS: begin
        work_o.term = sq_q;
        work_o.clip = wclip_q;
      end
      MODE_WRMS_MASK: begin
        work_o.term = sq_q;
        work_o.skip = !(msk_q > 0);
        work_o.clip = wclip_q && (msk_q > 0);
      end
      MODE_EQUALS: begin
        work_o.skip = 1'b1;
        work_o.neq  = adiff > {2'b0, tol_i};
      end
      default: work_o.skip = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      own_q  <= own_i;
      oth_q  <= oth_i;
      msk_q  <= msk_i;
      last_q <= last_i;
    end
    prod_q  <= prod_d;
    sq_q    <= sq_d;
    wclip_q <= wclip_d;
    num_q   <= num_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    step_q  <= step_d;
  end

endmodule

// ----- rtl/core/vre_queue.sv -----
// Small queue of classified elements between front and back.
module vre_queue import vre_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  output logic  ready_o,
  input  work_t data_i,
  output logic  valid_o,
  input  logic  pop_i,
  output work_t data_o
);

  work_t                  mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_q, rd_q;
  logic [QUEUE_PTR_W:0]   cnt_q;
  logic                   do_push, do_pop;

  assign ready_o = (cnt_q != QUEUE_PTR_W'(0) + (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem[wr_q] <= data_i;
  end

endmodule

// ----- rtl/core/vre_back.sv -----
// Back end: accumulates terms, finishes with divide-by-count and square root (WRMS modes) or square root alone (L2).
module vre_back import vre_pkg::*; #(
  parameter int unsigned CountBits = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mode_e       mode_i,
  input  logic        restart_i,
  input  mode_e       restart_mode_i,
  input  logic        work_valid_i,
  input  work_t       work_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_o,
  output logic        equal_o,
  output logic        sat_o
);

  back_state_e          state_q, state_d;
  logic signed [63:0]   acc_q, acc_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 eq_q, eq_d;
  logic                 clip_q, clip_d;
  logic [63:0]          res_q, res_d;
  logic [63:0]          dvd_q, dvd_d;
  logic [CountBits-1:0] drem_q, drem_d;
  logic [63:0]          dquo_q, dquo_d;
  logic [63:0]          rad_q, rad_d;
  logic [49:0]          srem_q, srem_d;
  logic [47:0]          root_q, root_d;
  logic [5:0]           step_q, step_d;

  // Saturating add of the incoming term
  logic signed [63:0] sum;
  logic               ovf;
  assign sum = acc_q + work_i.term;
  assign ovf = (acc_q[63] == work_i.term[63]) && (sum[63] != acc_q[63]);

  // Divider and root step datapaths
  logic [CountBits:0] dsh;
  logic [51:0]        sr, strial;
  assign dsh    = {drem_q, dvd_q[63]};
  assign sr     = {srem_q, rad_q[63:62]};
  assign strial = {2'b0, root_q, 2'b01};

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    eq_d    = eq_q;
    clip_d  = clip_q;
    res_d   = res_q;
    dvd_d   = dvd_q;
    drem_d  = drem_q;
    dquo_d  = dquo_q;
    rad_d   = rad_q;
    srem_d  = srem_q;
    root_d  = root_q;
    step_d  = step_q;
    pop_o   = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      B_RUN: begin
        if (work_valid_i) begin
          pop_o  = 1'b1;
          clip_d = clip_q | work_i.clip;
          if (mode_i == MODE_EQUALS && work_i.neq) eq_d = 1'b0;
          if (!work_i.skip) begin
            case (mode_i)
              MODE_MIN, MODE_MINQUOT: if (work_i.term < acc_q) acc_d = work_i.term;
              MODE_MAX, MODE_MAXABS:  if (work_i.term > acc_q) acc_d = work_i.term;
              MODE_L1, MODE_L2, MODE_DOT, MODE_WRMS, MODE_WRMS_MASK: begin
                acc_d = ovf ? (acc_q[63] ? S64_MIN : S64_MAX) : sum;
                if (ovf) clip_d = 1'b1;
              end
              default: ;
            endcase
          end
          if (!(&cnt_q)) cnt_d = cnt_q + 1'b1;
          if (work_i.last) begin
            step_d = '0;
            case (mode_i)
              MODE_L2: begin
                rad_d   = acc_d[63] ? '0 : acc_d;
                srem_d  = '0;
                root_d  = '0;
                state_d = B_SQRT;
              end
              MODE_WRMS, MODE_WRMS_MASK: begin
                dvd_d   = acc_d[63] ? '0 : acc_d;
                drem_d  = '0;
                dquo_d  = '0;
                state_d = B_DIV;
              end
              MODE_EQUALS: begin
                res_d   = eq_d ? Q32_ONE : '0;
                state_d = B_OUT;
              end
              MODE_MIN, MODE_MAX, MODE_L1, MODE_MAXABS, MODE_DOT, MODE_MINQUOT: begin
                res_d   = acc_d;
                state_d = B_OUT;
              end
              default: begin
                res_d   = '0;
                state_d = B_OUT;
              end
            endcase
          end
        end
      end
      B_DIV: begin
        // mean of squares: one quotient bit per cycle, count as divisor
        if (dsh >= {1'b0, cnt_q}) begin
          drem_d = CountBits'(dsh - {1'b0, cnt_q});
          dquo_d = {dquo_q[62:0], 1'b1};
        end else begin
          drem_d = dsh[CountBits-1:0];
          dquo_d = {dquo_q[62:0], 1'b0};
        end
        dvd_d  = {dvd_q[62:0], 1'b0};
        step_d = step_q + 6'd1;
        if (step_q == 6'd63) begin
          rad_d   = dquo_d;
          srem_d  = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = B_SQRT;
        end
      end
      B_SQRT: begin
        // two radicand bits per cycle, 48 root bits
        if (sr >= strial) begin
          srem_d = 50'(sr - strial);
          root_d = {root_q[46:0], 1'b1};
        end else begin
          srem_d = sr[49:0];
          root_d = {root_q[46:0], 1'b0};
        end
        rad_d  = {rad_q[61:0], 2'b00};
        step_d = step_q + 6'd1;
        if (step_q == 6'd47) begin
          res_d   = {16'b0, root_d};
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          acc_d   = init_acc(mode_i);
          cnt_d   = '0;
          eq_d    = 1'b1;
          clip_d  = 1'b0;
          state_d = B_RUN;
        end
      end
      default: state_d = B_RUN;
    endcase
    // mode write restarts the reduction
    if (restart_i) begin
      acc_d   = init_acc(restart_mode_i);
      cnt_d   = '0;
      eq_d    = 1'b1;
      clip_d  = 1'b0;
      state_d = B_RUN;
    end
  end

  assign result_o = res_q;
  assign equal_o  = (mode_i == MODE_EQUALS) && eq_q;
  assign sat_o    = clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_RUN;
      acc_q   <= S64_MAX;
      cnt_q   <= '0;
      eq_q    <= 1'b1;
      clip_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      eq_q    <= eq_d;
      clip_q  <= clip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    dvd_q  <= dvd_d;
    drem_q <= drem_d;
    dquo_q <= dquo_d;
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
    step_q <= step_d;
  end

endmodule

// ----- tb/vector_reduction_engine_tb.sv -----
// Self-checking testbench for the vector reduction engine: predicts every reduction result.
module vector_reduction_engine_tb;
  import vre_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 160;
  localparam int unsigned HOLD_CYCLES    = 400;

  // Expected reduction results and the predictor that forms them
  class reduction_scoreboard;
    logic [3:0]   mode;
    logic [30:0]  tol;
    longint       acc;
    logic [31:0]  count;
    bit           still_eq;
    bit           clipped;
    logic [63:0]  exp_value[$];
    logic [1:0]   exp_flags[$];
    int           errors;
    int           results;

    function new();
      mode = MODE_MIN;
      tol = '0;
      errors = 0;
      results = 0;
      restart();
    endfunction

    function void restart();
      case (mode)
        MODE_MIN, MODE_MINQUOT: acc = S64_MAX;
        MODE_MAX:               acc = S64_MIN;
        default:                acc = 0;
      endcase
      count = '0;
      still_eq = 1'b1;
      clipped = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      if (idx == CFG_MODE) begin
        mode = data[3:0];
        restart();
      end else if (idx == CFG_TOL) begin
        tol = data[30:0];
      end
    endfunction

    function longint add_clip(longint a, longint b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(S64_MAX)) begin
        clipped = 1'b1;
        return S64_MAX;
      end
      if (s < 65'(S64_MIN)) begin
        clipped = 1'b1;
        return S64_MIN;
      end
      return longint'(s);
    endfunction

    // Floor of the Q32.32 root of a Q32.32 value
    function longint root_q32(longint s);
      logic [127:0] v;
      logic [63:0]  r;
      logic [63:0]  c;
      v = (s < 0) ? '0 : (128'(s) << 32);
      r = '0;
      for (int b = 47; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (128'(c) * 128'(c) <= v) r = c;
      end
      return longint'(r);
    endfunction

    function longint weighted_square(longint a, longint b);
      longint w;
      w = (a * b) >>> 16;
      if (w > 64'sd2147483647) begin
        w = 64'sd2147483647;
        clipped = 1'b1;
      end
      if (w < -64'sd2147483648) begin
        w = -64'sd2147483648;
        clipped = 1'b1;
      end
      return w * w;
    endfunction

    // num / den in Q32.32, truncated toward zero, clipped to the format
    function longint ratio_q32(longint num, longint den);
      logic [63:0] na;
      logic [63:0] nb;
      logic [63:0] mag;
      bit          neg;
      na = 64'(num < 0 ? -num : num) << 32;
      nb = 64'(den < 0 ? -den : den);
      mag = na / nb;
      neg = (num < 0) != (den < 0);
      if (!neg) begin
        if (mag > 64'(S64_MAX)) begin
          clipped = 1'b1;
          return S64_MAX;
        end
        return longint'(mag);
      end
      if (mag > (64'd1 << 63)) begin
        clipped = 1'b1;
        return S64_MIN;
      end
      if (mag == (64'd1 << 63)) return S64_MIN;
      return -longint'(mag);
    endfunction

    function void note_element(logic [31:0] own_r, logic [31:0] oth_r,
                               logic [31:0] msk_r, bit last);
      longint own;
      longint oth;
      longint msk;
      longint q;
      longint aq;
      longint d;
      longint res;
      logic [63:0] n;
      logic [63:0] a;
      own = longint'(signed'(own_r));
      oth = longint'(signed'(oth_r));
      msk = longint'(signed'(msk_r));
      q = own * 65536;
      aq = (q < 0) ? -q : q;
      case (mode)
        MODE_MIN:    if (q < acc) acc = q;
        MODE_MAX:    if (q > acc) acc = q;
        MODE_L1:     acc = add_clip(acc, aq);
        MODE_L2:     acc = add_clip(acc, own * own);
        MODE_MAXABS: if (aq > acc) acc = aq;
        MODE_DOT:    acc = add_clip(acc, own * oth);
        MODE_MINQUOT: begin
          if (own != 0) begin
            d = ratio_q32(oth, own);
            if (d < acc) acc = d;
          end
        end
        MODE_WRMS: acc = add_clip(acc, weighted_square(own, oth));
        MODE_WRMS_MASK: begin
          if (msk > 0) acc = add_clip(acc, weighted_square(own, oth));
        end
        MODE_EQUALS: begin
          d = own - oth;
          if (d < 0) d = -d;
          if (d > longint'(tol)) still_eq = 1'b0;
        end
        default: ;
      endcase
      if (count != '1) count++;
      if (!last) return;
      case (mode)
        MODE_L2: res = root_q32(acc);
        MODE_WRMS, MODE_WRMS_MASK: begin
          n = (count == 0) ? 64'd1 : 64'(count);
          a = (acc < 0) ? '0 : 64'(acc);
          res = root_q32(longint'(a / n));
        end
        MODE_EQUALS: res = still_eq ? Q32_ONE : 0;
        default:     res = (mode <= MODE_MINQUOT) ? acc : 0;
      endcase
      exp_value.push_back(64'(res));
      exp_flags.push_back({clipped, bit'(mode == MODE_EQUALS && still_eq)});
      restart();
    endfunction

    function void check(logic [63:0] value, logic [1:0] flags);
      logic [63:0] ev;
      logic [1:0]  ef;
      results++;
      if (exp_value.size() == 0) begin
        $display("%0t: unexpected result %h flags %b", $time, value, flags);
        errors++;
        return;
      end
      ev = exp_value.pop_front();
      ef = exp_flags.pop_front();
      if (value !== ev) begin
        $display("%0t: result expected %h actual %h", $time, ev, value);
        errors++;
      end
      if (flags[0] !== ef[0]) begin
        $display("%0t: equal_flag expected %b actual %b", $time, ef[0], flags[0]);
        errors++;
      end
      if (flags[1] !== ef[1]) begin
        $display("%0t: saturated expected %b actual %b", $time, ef[1], flags[1]);
        errors++;
      end
    endfunction

    function int pending();
      return exp_value.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [95:0]          s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [63:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [31:0]          cfg_data_i;

  reduction_scoreboard sb = new();
  bit          no_idle;
  bit          hold_req;
  int unsigned elements;
  int unsigned vectors;
  int unsigned quiet;

  vector_reduction_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Element value biased toward the interesting corners
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'(signed'($urandom_range(0, 8)) - 4);
      4, 5:    return 32'(signed'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_element(logic [31:0] own, logic [31:0] oth, logic [31:0] msk,
                              bit last);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {msk, oth, own};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_element(own, oth, msk, last);
    elements++;
    if (last) vectors++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    s_axis_tvalid <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every result, then let the back end settle before reconfiguring
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_vectors(int unsigned budget);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      for (int unsigned i = 1; i <= len; i++)
        send_element(pick_value(), pick_value(), pick_value(), i == len);
      sent += len;
    end
  endtask

  // Corner vectors of each mode
  task automatic directed_vectors(logic [3:0] m);
    case (m)
      MODE_MIN, MODE_MAX, MODE_MAXABS: begin
        send_element(32'h8000_0000, 32'h0, 32'h0, 1'b0);
        send_element(32'h7FFF_FFFF, 32'h0, 32'h0, 1'b1);
      end
      MODE_L2, MODE_DOT, MODE_L1: begin
        send_element(32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0);
        send_element(32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1);
      end
      MODE_MINQUOT: begin
        // only zero divisors, then clip on a positive overflow, then the exact negative limit
        send_element(32'h0, 32'h1234_5678, 32'h0, 1'b1);
        send_element(32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
        send_element(32'h0000_0001, 32'h8000_0000, 32'h0, 1'b1);
      end
      MODE_WRMS: send_element(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1);
      MODE_WRMS_MASK: begin
        send_element(32'h0001_0000, 32'h0003_0000, 32'hFFFF_FFFF, 1'b0);
        send_element(32'h0002_0000, 32'h0002_0000, 32'h0, 1'b0);
        send_element(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
      end
      MODE_EQUALS: begin
        send_element(32'h8000_0000, 32'h8000_0000, 32'h0, 1'b1);
        send_element(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1);
      end
      default: send_element($urandom, $urandom, $urandom, 1'b1);
    endcase
  endtask

  // Stimulus
  initial begin
    logic [3:0] modes[$];
    int unsigned ph;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MODE;
    cfg_data_i = '0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    elements = 0;
    vectors = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings first, before any register write
    send_element(32'h0001_0000, 32'h0, 32'h0, 1'b1);
    drain();

    modes = '{MODE_MIN, MODE_MAX, MODE_L1, MODE_L2, MODE_MAXABS, MODE_DOT, MODE_MINQUOT,
              MODE_WRMS, MODE_WRMS_MASK, MODE_EQUALS, 4'd12, 4'd15, MODE_EQUALS};
    ph = 0;
    foreach (modes[k]) begin
      no_idle = (ph % 3 == 1);
      // high data bits of the mode register are dont-care
      write_reg(CFG_MODE, ($urandom & 32'hFFFF_FFF0) | 32'(modes[k]));
      case (ph % 4)
        0: write_reg(CFG_TOL, 32'h0);
        1: write_reg(CFG_TOL, 32'hFFFF_FFFF);
        2: write_reg(CFG_TOL, $urandom_range(0, 1 << 22));
        default: write_reg(CFG_TOL, $urandom);
      endcase
      // unused indexes must leave both registers alone
      write_reg(2'd2, $urandom);
      write_reg(2'd3, $urandom);
      directed_vectors(modes[k]);
      if (modes[k] == MODE_DOT) hold_req = 1'b1;
      random_vectors(modes[k] == MODE_MINQUOT ? 60 : 100);
      drain();
      ph++;
    end

    drain();
    $display("Covered %0d elements in %0d vectors over all reduction modes,", elements,
             vectors);
    $display("with corner values, tolerance extremes and back-pressure on both ports.");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Result receiver with random stalls and one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (no_idle) begin
        m_axis_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tuser);
  end

  // Watchdog on cycles without any request moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no request for %0d cycles", $time, quiet);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
